// File: rtl/core/tct_pkg.sv
package tct_pkg;

    localparam int unsigned EntriesDefault = 16;

    localparam logic [31:0] EstabTimeoutReset = 32'd7440;
    localparam logic [31:0] TransTimeoutReset = 32'd300;

    localparam logic CfgIdxEstab = 1'b0;
    localparam logic CfgIdxTrans = 1'b1;

    localparam logic ModePacket = 1'b0;
    localparam logic ModeTick   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLOSED     = 4'd0,
        ST_SYN_SENT   = 4'd1,
        ST_SYN_RCVD   = 4'd2,
        ST_SYN_PROC   = 4'd3,
        ST_ESTAB      = 4'd4,
        ST_FIN_WAIT1  = 4'd5,
        ST_FIN_WAIT2  = 4'd6,
        ST_CLOSE_WAIT = 4'd7,
        ST_LAST_ACK   = 4'd8,
        ST_TIME_WAIT  = 4'd9
    } t_conn_state;

    typedef struct packed {
        logic        mode;
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic        incoming;
        logic        flag_syn;
        logic        flag_ack;
        logic        flag_fin;
        logic        flag_rst;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic       table_full;
        logic [3:0] conn_state;
        logic [4:0] expired_count;
        logic       table_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_APPLY,
        BK_TICK,
        BK_DONE
    } t_back_state;

    // Rule result for one packet against one entry.
    typedef struct packed {
        logic [3:0]  state;
        logic        wr_sent;
        logic [31:0] sent;
        logic        wr_recv;
        logic [31:0] recv;
    } t_rule_res;

    function automatic t_rule_res apply_rules(
        input logic [3:0]  cur,
        input logic        inc,
        input logic        syn,
        input logic        ack,
        input logic        fin,
        input logic        rst,
        input logic [31:0] seq,
        input logic [31:0] ackn,
        input logic [31:0] fsent
    );
        t_rule_res r;
        logic [3:0] s;
        r = '0;
        s = rst ? ST_CLOSED : cur;
        r.state = s;
        if (inc) begin
            unique case (s)
                ST_CLOSED: begin
                    if (syn) begin
                        r.state = ST_SYN_PROC;
                        r.wr_sent = 1'b1; r.wr_recv = 1'b1;
                    end
                end
                ST_SYN_SENT: begin
                    if (syn) r.state = ack ? ST_ESTAB : ST_SYN_RCVD;
                    else if (ack) r.state = ST_ESTAB;
                end
                ST_SYN_RCVD: if (ack) r.state = ST_ESTAB;
                ST_ESTAB, ST_FIN_WAIT1, ST_FIN_WAIT2: begin
                    if (fin) begin
                        r.state = (s == ST_ESTAB) ? ST_CLOSE_WAIT : ST_TIME_WAIT;
                        r.wr_recv = 1'b1; r.recv = seq;
                    end
                    if (s == ST_FIN_WAIT1 && ack && ackn > fsent) r.state = ST_FIN_WAIT2;
                    if (syn) begin
                        r.state = ST_SYN_PROC;
                        r.wr_sent = 1'b1; r.sent = '0;
                        r.wr_recv = 1'b1; r.recv = '0;
                    end
                end
                ST_CLOSE_WAIT: begin
                    if (fin) begin
                        r.state = ST_LAST_ACK;
                        r.wr_sent = 1'b1; r.sent = seq;
                    end
                    if (syn) begin
                        r.state = ST_SYN_SENT;
                        r.wr_sent = 1'b1; r.sent = '0;
                        r.wr_recv = 1'b1; r.recv = '0;
                    end
                end
                default: ;
            endcase
        end else begin
            unique case (s)
                ST_SYN_PROC: if (syn && ack) r.state = ST_SYN_RCVD;
                ST_ESTAB, ST_CLOSE_WAIT: begin
                    if (fin) begin
                        r.state = (s == ST_ESTAB) ? ST_FIN_WAIT1 : ST_LAST_ACK;
                        r.wr_sent = 1'b1; r.sent = seq;
                    end
                    if (syn) begin
                        r.state = ST_SYN_SENT;
                        r.wr_sent = 1'b1; r.sent = '0;
                        r.wr_recv = 1'b1; r.recv = '0;
                    end
                end
                ST_CLOSED, ST_LAST_ACK, ST_TIME_WAIT: begin
                    if (syn) begin
                        r.state = ST_SYN_SENT;
                        r.wr_sent = 1'b1; r.sent = '0;
                        r.wr_recv = 1'b1; r.recv = '0;
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tcp_connection_tracker_top.sv
// TCP connection tracker for the connections of one NAT mapping. Items enter on a
// valid/stall channel (mode 0 packet, 1 tick) and each gives exactly one result. A
// two-item queue decouples the input from the table walker, which visits one table
// entry per cycle: a packet is scanned, applied and reported, and a tick walks the
// table for expiry and then reports, one item at a time. A packet
// matches on remote address and port, else takes the lowest free slot, else is
// reported as table_full with no change. A tick advances time by one and drops
// entries idle longer than their timeout. Timeouts are written through the plain
// register port and must be changed only while the block is idle.
module tcp_connection_tracker_top import tct_pkg::*; #(
    parameter int unsigned ENTRIES = EntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic        q_valid;
    t_in_item    q_item;
    logic        q_pop;
    logic [31:0] r_estab_to;
    logic [31:0] r_trans_to;

    // Hold timeout registers; write by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estab_to <= EstabTimeoutReset;
            r_trans_to <= TransTimeoutReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgIdxEstab) r_estab_to <= i_cfg_data;
            if (i_cfg_idx == CfgIdxTrans) r_trans_to <= i_cfg_data;
        end
    end

    tct_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    tct_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .i_estab_to (r_estab_to),
        .i_trans_to (r_trans_to),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

// File: rtl/core/tct_front.sv
// Input stage and two-entry queue toward the back end.
module tct_front import tct_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_q_valid,
    output t_in_item o_q_item,
    input  logic     i_q_pop
);

    t_in_item r_q [2];
    logic     r_wp;
    logic     r_rp;
    logic [1:0] r_cnt;
    logic     push;
    logic     pop;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !pop) else $error("pop while empty");
    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers out of step");

endmodule

// File: rtl/core/tct_back.sv
// Table walk: one entry a cycle for lookup and for expiry.
module tct_back import tct_pkg::*; #(
    parameter int unsigned ENTRIES = EntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_in_item    i_q_item,
    output logic        o_q_pop,
    input  logic [31:0] i_estab_to,
    input  logic [31:0] i_trans_to,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [31:0] r_ip   [ENTRIES];
    logic [15:0] r_port [ENTRIES];
    logic [3:0]  r_st   [ENTRIES];
    logic [31:0] r_fs   [ENTRIES];
    logic [31:0] r_fr   [ENTRIES];
    logic [31:0] r_ls   [ENTRIES];
    logic [ENTRIES-1:0] r_vld;

    t_back_state r_bs, n_bs;
    t_in_item    r_cur;
    logic [CW-1:0] r_idx, n_idx;
    logic        r_hit, n_hit;
    logic        r_free, n_free;
    logic [IW-1:0] r_slot, n_slot;
    logic [4:0]  r_exp, n_exp;
    logic [31:0] r_now;
    t_out_item   r_out, n_out;
    logic        r_ov;

    logic [IW-1:0] ix;
    logic [31:0] rd_ip, rd_ls, rd_fs;
    logic [15:0] rd_port;
    logic [3:0]  rd_st;
    logic        rd_v;
    logic        match;
    logic        last;
    logic        expire;
    logic [31:0] idle;
    t_rule_res   rr;
    logic        do_upd, do_new, do_expire, do_load;

    assign ix      = r_idx[IW-1:0];
    assign rd_ip   = r_ip[ix];
    assign rd_port = r_port[ix];
    assign rd_st   = r_st[ix];
    assign rd_ls   = r_ls[ix];
    assign rd_v    = r_vld[ix];
    assign rd_fs   = r_fs[r_slot];
    assign match   = rd_v && rd_ip == r_cur.remote_ip && rd_port == r_cur.remote_port;
    assign last    = (r_idx == CW'(ENTRIES - 1));
    assign idle    = r_now - rd_ls;
    assign expire  = rd_v && (idle > ((rd_st == ST_ESTAB) ? i_estab_to : i_trans_to));
    assign rr      = apply_rules(r_st[r_slot], r_cur.incoming, r_cur.flag_syn,
                                 r_cur.flag_ack, r_cur.flag_fin, r_cur.flag_rst,
                                 r_cur.seq_num, r_cur.ack_num, rd_fs);

    always_comb begin
        n_bs = r_bs; n_idx = r_idx; n_hit = r_hit; n_free = r_free;
        n_slot = r_slot; n_exp = r_exp; n_out = r_out;
        o_q_pop = 1'b0; do_upd = 1'b0; do_new = 1'b0; do_expire = 1'b0; do_load = 1'b0;
        unique case (r_bs)
            BK_IDLE: begin
                if (i_q_valid && !(r_ov && i_stall)) begin
                    o_q_pop = 1'b1; do_load = 1'b1;
                    n_idx = '0; n_hit = 1'b0; n_free = 1'b0; n_exp = '0;
                    n_bs = (i_q_item.mode == ModeTick) ? BK_TICK : BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (!r_hit && match) begin
                    n_hit = 1'b1; n_slot = ix;
                end else if (!r_hit && !r_free && !rd_v) begin
                    n_free = 1'b1; n_slot = ix;
                end
                n_idx = r_idx + 1'b1;
                if (last) n_bs = BK_APPLY;
            end
            BK_APPLY: begin
                n_out = '0;
                if (r_hit) begin
                    do_upd = 1'b1;
                    n_out.found = 1'b1;
                    n_out.conn_state = rr.state;
                end else if (r_free) begin
                    do_new = 1'b1;
                    n_out.conn_state = r_cur.flag_syn ?
                        (r_cur.incoming ? ST_SYN_PROC : ST_SYN_SENT) : ST_CLOSED;
                end else begin
                    n_out.table_full = 1'b1;
                end
                n_out.table_empty = !(r_hit || r_free) && (r_vld == '0);
                n_bs = BK_DONE;
            end
            BK_TICK: begin
                if (expire) begin
                    do_expire = 1'b1;
                    if (r_exp != 5'd31) n_exp = r_exp + 5'd1;
                end
                n_idx = r_idx + 1'b1;
                if (last) begin
                    n_out = '0;
                    n_out.expired_count = n_exp;
                    n_bs = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out.table_full && r_cur.mode == ModePacket) n_out.table_empty = 1'b0;
                else if (r_cur.mode == ModeTick) n_out.table_empty = (r_vld == '0);
                n_bs = BK_IDLE;
            end
            default: n_bs = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_load) r_cur <= i_q_item;
        if (do_upd) begin
            r_st[r_slot] <= rr.state;
            if (rr.wr_sent) r_fs[r_slot] <= rr.sent;
            if (rr.wr_recv) r_fr[r_slot] <= rr.recv;
            r_ls[r_slot] <= r_now;
        end
        if (do_new) begin
            r_ip[r_slot]   <= r_cur.remote_ip;
            r_port[r_slot] <= r_cur.remote_port;
            r_st[r_slot]   <= r_cur.flag_syn ?
                (r_cur.incoming ? ST_SYN_PROC : ST_SYN_SENT) : ST_CLOSED;
            r_fs[r_slot]   <= '0;
            r_fr[r_slot]   <= '0;
            r_ls[r_slot]   <= r_now;
        end
        r_idx <= n_idx; r_hit <= n_hit; r_free <= n_free;
        r_slot <= n_slot; r_exp <= n_exp; r_out <= n_out;
        if (!i_rst_n) begin
            r_bs  <= BK_IDLE;
            r_vld <= '0;
            r_now <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_bs <= n_bs;
            if (do_new) r_vld[r_slot] <= 1'b1;
            if (do_expire) r_vld[ix] <= 1'b0;
            if (do_load && i_q_item.mode == ModeTick) r_now <= r_now + 32'd1;
            if (r_bs == BK_DONE) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_DONE) |-> !(r_ov && i_stall)) else $error("result overwritten");
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_APPLY && !r_hit && !r_free) |-> (r_vld == '1))
        else $error("table full with a free slot");
    a_tick_no_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bs == BK_TICK) |-> !do_new) else $error("allocation during tick");

endmodule
